/* design/ophp_pkg.sv */
// Shared constants and types for the one-pole high-pass filter.
`timescale 1ns / 1ps
`default_nettype none
package ophp_pkg;

  localparam int CUTOFF_W   = 17;
  localparam int RATE_W     = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int LP_FRAC    = 16;

  // Divider port widths: the largest dividend is cutoff * 2^32.
  localparam int DIV_N_W = CUTOFF_W + 32;
  localparam int DIV_D_W = RATE_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 1'b1;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RST = 17'd0;
  localparam logic [RATE_W-1:0]   RATE_RST   = 18'd44100;

  // Angles and unity in Q2.30.
  localparam logic [33:0] Q30_ONE     = 34'd1073741824;
  localparam logic [33:0] Q30_PI      = 34'd3373259426;
  localparam logic [33:0] Q30_HALF_PI = 34'd1686629713;
  // Low 32 bits of 2*pi in Q30; the upper part is exactly 2^32.
  localparam logic [31:0] TWO_PI_LO   = 32'd2451551556;

  typedef logic [CUTOFF_W-1:0] cutoff_t;
  typedef logic [RATE_W-1:0]   rate_t;

endpackage
`default_nettype wire

/* design/ophp_if.sv */
// Sample stream interfaces for the filter input and output channels.
`timescale 1ns / 1ps
`default_nettype none
interface ophp_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface ophp_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface
`default_nettype wire

/* design/one_pole_highpass_filter.sv */
// One-pole high-pass filter: sequencer around a shared multiplier and divider.
//
// Samples enter on in_i and results leave on out_o, both valid/ready
// streams; a transfer happens when valid and ready are high at a clock edge.
// Each input sample gives exactly one output sample, in order.
// Registers cutoff_hz (index 0) and sample_rate (index 1) are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while the
// block is idle, as the block itself does not enforce it.
// When the cutoff is unchanged a sample steps through S_FILT_A, S_FILT_B,
// S_FILT_C, S_OUT (two multiplies on the shared multiplier plus accumulate).
// When the cutoff changed to a nonzero value at most half the sample rate,
// the gains are derived first: a division for the frequency ratio, a Horner
// cosine series of ITERATIONS terms (one multiply and one division per term),
// and a bit-serial square root; other new cutoffs set the gains directly.
// in_i.ready is high only while the sequencer is idle. The result sits in an
// output register, so the next sample is taken while the receiver stalls;
// the sequencer waits only if a second result is ready before the first
// has been taken. Reset (rst_ni low) clears the filter state and gains,
// sets the cutoff to 0 and the sample rate to 44100; the input then passes
// through unchanged until a new cutoff is applied.
`timescale 1ns / 1ps
`default_nettype none
module one_pole_highpass_filter #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEFF_WIDTH  = 32,
  parameter int ITERATIONS   = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  ophp_in_if.sink                                in_i,
  ophp_out_if.source                             out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [ophp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ophp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ophp_pkg::*;

  localparam int LP_W       = SAMPLE_WIDTH + LP_FRAC;
  localparam int COEFF_FRAC = COEFF_WIDTH - 2;
  localparam int MUL_W0     = (COEFF_WIDTH > 34) ? COEFF_WIDTH : 34;
  localparam int MUL_W      = (LP_W > MUL_W0) ? LP_W : MUL_W0;
  localparam int P_W        = 2 * MUL_W;
  localparam int SW         = P_W + 2;
  localparam int K_W        = $clog2(ITERATIONS + 1);
  localparam int M_MAX      = (2 * ITERATIONS - 1) * 2 * ITERATIONS;
  localparam int M_W        = $clog2(M_MAX + 1);
  localparam int SHL        = (COEFF_FRAC >= 30) ? COEFF_FRAC - 30 : 0;
  localparam int SHR        = (COEFF_FRAC < 30) ? 30 - COEFF_FRAC : 1;
  localparam int GW         = COEFF_WIDTH + 34;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RATIO,
    S_TH_MUL,
    S_TH,
    S_U2_MUL,
    S_U2,
    S_H_MUL,
    S_H_DIV,
    S_H_WAIT,
    S_CLAMP,
    S_C_MUL,
    S_D,
    S_SQRT,
    S_GAIN,
    S_FILT_A,
    S_FILT_B,
    S_FILT_C,
    S_OUT
  } state_e;

  function automatic logic [COEFF_WIDTH-1:0] to_coeff(input logic [33:0] v);
    logic [GW-1:0] w;
    w = {{COEFF_WIDTH{1'b0}}, v};
    if (COEFF_FRAC >= 30) begin
      w = w << SHL;
    end else begin
      w = (w + ({{(GW-1){1'b0}}, 1'b1} << (SHR - 1))) >> SHR;
    end
    return w[COEFF_WIDTH-1:0];
  endfunction

  state_e                          state_q;
  cutoff_t                         cutoff_q;
  rate_t                           rate_q;
  cutoff_t                         applied_q;
  logic [COEFF_WIDTH-1:0]          gain_a_q;
  logic [COEFF_WIDTH-1:0]          gain_b_q;
  logic signed [LP_W-1:0]          lp_q;
  logic signed [SAMPLE_WIDTH-1:0]  x_q;
  logic [31:0]                     r_q;
  logic [30:0]                     u_q;
  logic                            neg_q;
  logic [31:0]                     u2_q;
  logic signed [33:0]              acc_q;
  logic [K_W-1:0]                  k_q;
  logic                            sgn_q;
  logic [31:0]                     c_q;
  logic [63:0]                     rem_q;
  logic [63:0]                     root_q;
  logic [4:0]                      pos_q;
  logic signed [SW-1:0]            facc_q;
  logic signed [SAMPLE_WIDTH-1:0]  res_q;
  logic                            out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0]  out_data_q;

  logic                     in_xfer;
  logic                     out_xfer;
  logic                     need_new;
  logic                     need_div;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [P_W-1:0]           prod;
  logic                     div_start;
  logic [DIV_N_W-1:0]       div_dividend;
  logic [DIV_D_W-1:0]       div_divisor;
  logic                     div_done;
  logic [DIV_N_W-1:0]       div_quot;

  logic signed [LP_W-1:0]   xs;
  logic [LP_W-1:0]          xs_mag;
  logic [LP_W-1:0]          lp_mag;
  logic [33:0]              acc_mag;
  logic [32:0]              theta;
  logic signed [34:0]       folded;
  logic [30:0]              u_d;
  logic                     neg_d;
  logic [K_W:0]             tk;
  logic [M_W-1:0]           m_val;
  logic signed [35:0]       q_s;
  logic signed [35:0]       acc_n;
  logic signed [33:0]       acc_cl;
  logic signed [34:0]       c_full;
  logic [63:0]              bitv;
  logic [64:0]              trial;
  logic                     ge;
  logic [31:0]              b_q30;
  logic [33:0]              a_q30;
  logic signed [SW-1:0]     p_s;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     y_full;
  logic signed [LP_W-1:0]   lp_d;
  logic signed [LP_W+1:0]   o_full;
  logic signed [SAMPLE_WIDTH+1:0] o_top;
  logic signed [SAMPLE_WIDTH-1:0] res_d;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  assign need_new = (cutoff_q != applied_q);
  assign need_div = need_new && (cutoff_q != '0) && ({cutoff_q, 1'b0} <= rate_q);

  always_comb begin
    xs      = {x_q, {LP_FRAC{1'b0}}};
    xs_mag  = xs[LP_W-1] ? LP_W'(-xs) : LP_W'(xs);
    lp_mag  = lp_q[LP_W-1] ? LP_W'(-lp_q) : LP_W'(lp_q);
    acc_mag = acc_q[33] ? 34'(-acc_q) : 34'(acc_q);

    // theta = r + (r * low part of 2*pi) / 2^32
    theta  = {1'b0, prod[63:32]} + {1'b0, r_q};
    neg_d  = ({1'b0, theta} > Q30_HALF_PI);
    folded = neg_d ? $signed({1'b0, Q30_PI}) - $signed({2'b0, theta})
                   : $signed({2'b0, theta});
    u_d    = folded[34] ? '0 : folded[30:0];

    tk    = {k_q, 1'b0};
    m_val = M_W'(tk) * M_W'(tk - 1'b1);

    q_s   = sgn_q ? -$signed({2'b0, div_quot[33:0]}) : $signed({2'b0, div_quot[33:0]});
    acc_n = $signed({2'b0, Q30_ONE}) - q_s;

    // clamp the reduced cosine to [0, 1], then apply the fold sign
    if (acc_q[33]) begin
      acc_cl = '0;
    end else if (acc_q > $signed(Q30_ONE)) begin
      acc_cl = $signed(Q30_ONE);
    end else begin
      acc_cl = acc_q;
    end
    c_full = $signed(35'sd2147483648) - (neg_q ? -35'(acc_cl) : 35'(acc_cl));

    bitv  = 64'd1 << {pos_q, 1'b0};
    trial = {1'b0, root_q} + {1'b0, bitv};
    ge    = {1'b0, rem_q} >= trial;

    b_q30 = c_q - root_q[31:0];
    a_q30 = Q30_ONE - {2'b0, b_q30};

    p_s    = $signed({2'b0, prod});
    sum    = facc_q + (lp_q[LP_W-1] ? -p_s : p_s);
    y_full = (sum + $signed({{(SW-1){1'b0}}, 1'b1} << (COEFF_FRAC - 1))) >>> COEFF_FRAC;
    if (!((&y_full[SW-1:LP_W-1]) || !(|y_full[SW-1:LP_W-1]))) begin
      lp_d = y_full[SW-1] ? {1'b1, {(LP_W-1){1'b0}}} : {1'b0, {(LP_W-1){1'b1}}};
    end else begin
      lp_d = y_full[LP_W-1:0];
    end
    o_full = ($signed({{2{xs[LP_W-1]}}, xs}) - $signed({{2{lp_d[LP_W-1]}}, lp_d})
              + $signed((LP_W+2)'(1) << (LP_FRAC - 1))) >>> LP_FRAC;
    o_top  = o_full[SAMPLE_WIDTH+1:0];
    if (!((&o_top[SAMPLE_WIDTH+1:SAMPLE_WIDTH-1]) ||
          !(|o_top[SAMPLE_WIDTH+1:SAMPLE_WIDTH-1]))) begin
      res_d = o_top[SAMPLE_WIDTH+1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      res_d = o_top[SAMPLE_WIDTH-1:0];
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_TH_MUL: begin
        mul_a = MUL_W'(r_q);
        mul_b = MUL_W'(TWO_PI_LO);
      end
      S_U2_MUL: begin
        mul_a = MUL_W'(u_q);
        mul_b = MUL_W'(u_q);
      end
      S_H_MUL: begin
        mul_a = MUL_W'(u2_q);
        mul_b = MUL_W'(acc_mag);
      end
      S_C_MUL: begin
        mul_a = MUL_W'(c_q);
        mul_b = MUL_W'(c_q);
      end
      S_FILT_A: begin
        mul_a = MUL_W'(gain_a_q);
        mul_b = MUL_W'(xs_mag);
      end
      S_FILT_B: begin
        mul_a = MUL_W'(gain_b_q);
        mul_b = MUL_W'(lp_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start    = (in_xfer && need_div) || (state_q == S_H_DIV);
  assign div_dividend = (state_q == S_H_DIV) ? DIV_N_W'(prod[63:30])
                                             : {cutoff_q, 32'd0};
  assign div_divisor  = (state_q == S_H_DIV) ? DIV_D_W'(m_val) : rate_q;

  ophp_mul #(
    .MUL_W (MUL_W)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ophp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cutoff_q    <= CUTOFF_RST;
      rate_q      <= RATE_RST;
      applied_q   <= '0;
      gain_a_q    <= '0;
      gain_b_q    <= '0;
      lp_q        <= '0;
      x_q         <= '0;
      r_q         <= '0;
      u_q         <= '0;
      neg_q       <= 1'b0;
      u2_q        <= '0;
      acc_q       <= '0;
      k_q         <= '0;
      sgn_q       <= 1'b0;
      c_q         <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      pos_q       <= '0;
      facc_q      <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CUTOFF: cutoff_q <= cfg_data_i[CUTOFF_W-1:0];
          CFG_RATE:   rate_q   <= cfg_data_i[RATE_W-1:0];
          default:    ;
        endcase
      end

      // in S_OUT the output register is reloaded below
      if (out_xfer && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            x_q <= in_i.sample_in;
            if (need_new) begin
              applied_q <= cutoff_q;
              if (cutoff_q == '0) begin
                gain_a_q <= to_coeff(Q30_ONE);
                gain_b_q <= '0;
                state_q  <= S_FILT_A;
              end else if (need_div) begin
                state_q <= S_RATIO;
              end else begin
                gain_a_q <= '0;
                gain_b_q <= '0;
                state_q  <= S_FILT_A;
              end
            end else begin
              state_q <= S_FILT_A;
            end
          end
        end
        S_RATIO: begin
          if (div_done) begin
            r_q     <= div_quot[31:0];
            state_q <= S_TH_MUL;
          end
        end
        S_TH_MUL: state_q <= S_TH;
        S_TH: begin
          u_q     <= u_d;
          neg_q   <= neg_d;
          state_q <= S_U2_MUL;
        end
        S_U2_MUL: state_q <= S_U2;
        S_U2: begin
          u2_q    <= prod[61:30];
          acc_q   <= $signed(Q30_ONE);
          k_q     <= K_W'(ITERATIONS);
          state_q <= S_H_MUL;
        end
        S_H_MUL: begin
          sgn_q   <= acc_q[33];
          state_q <= S_H_DIV;
        end
        S_H_DIV: state_q <= S_H_WAIT;
        S_H_WAIT: begin
          if (div_done) begin
            acc_q <= acc_n[33:0];
            if (k_q == K_W'(1)) begin
              state_q <= S_CLAMP;
            end else begin
              k_q     <= k_q - 1'b1;
              state_q <= S_H_MUL;
            end
          end
        end
        S_CLAMP: begin
          c_q     <= c_full[31:0];
          state_q <= S_C_MUL;
        end
        S_C_MUL: state_q <= S_D;
        S_D: begin
          // c*c - 2^60 as the radicand
          rem_q   <= prod[63:0] - 64'h1000_0000_0000_0000;
          root_q  <= '0;
          pos_q   <= 5'd31;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (ge) begin
            rem_q  <= rem_q - trial[63:0];
            root_q <= (root_q >> 1) + bitv;
          end else begin
            root_q <= root_q >> 1;
          end
          if (pos_q == '0) begin
            state_q <= S_GAIN;
          end else begin
            pos_q <= pos_q - 1'b1;
          end
        end
        S_GAIN: begin
          gain_b_q <= to_coeff({2'b0, b_q30});
          gain_a_q <= to_coeff(a_q30);
          state_q  <= S_FILT_A;
        end
        S_FILT_A: state_q <= S_FILT_B;
        S_FILT_B: begin
          facc_q  <= xs[LP_W-1] ? -p_s : p_s;
          state_q <= S_FILT_C;
        end
        S_FILT_C: begin
          lp_q    <= lp_d;
          res_q   <= res_d;
          state_q <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || out_xfer) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* design/ophp_mul.sv */
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module ophp_mul #(
  parameter int MUL_W = 34
) (
  input  wire logic                 clk_i,
  input  wire logic [MUL_W-1:0]     a_i,
  input  wire logic [MUL_W-1:0]     b_i,
  output logic      [2*MUL_W-1:0]   p_o
);

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* design/ophp_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ophp_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ophp_pkg::DIV_N_W-1:0]  dividend_i,
  input  wire logic [ophp_pkg::DIV_D_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic      [ophp_pkg::DIV_N_W-1:0]  quot_o
);
  import ophp_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [DIV_D_W-1:0] div_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [DIV_N_W-1:0] quo_q;

  logic [DIV_D_W:0] rem_sh;
  logic             fits;
  logic [DIV_D_W:0] rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_N_W-1]};
    fits    = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(DIV_N_W);
        busy_q <= 1'b1;
        div_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
        quo_q <= {quo_q[DIV_N_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire
